// ===== rtl/ctcc_pkg.sv =====
package ctcc_pkg;

	localparam int unsigned DivBits   = 26;
	localparam int unsigned MWidth    = 7;
	localparam int unsigned VcoWidth  = DivBits + 9;
	localparam int unsigned SysWidth  = 28;

	localparam logic [1:0] SrcHsi     = 2'd0;
	localparam logic [1:0] SrcHse     = 2'd1;
	localparam logic [1:0] SrcPll     = 2'd2;
	localparam logic [1:0] SrcBad     = 2'd3;

	localparam logic       RegHse     = 1'b0;
	localparam logic       RegHsi     = 1'b1;

	localparam logic [1:0] PDiv2      = 2'd0;
	localparam logic [1:0] PDiv4      = 2'd1;
	localparam logic [1:0] PDiv6      = 2'd2;
	localparam logic [1:0] PDiv8      = 2'd3;

	localparam logic [SysWidth-1:0] SysMaxHz  = 28'd168000000;
	localparam logic [SysWidth-1:0] Apb1MaxHz = 28'd42000000;
	localparam logic [SysWidth-1:0] Apb2MaxHz = 28'd84000000;
	localparam logic [DivBits-1:0]  VinMinHz  = 26'd1000000;
	localparam logic [DivBits-1:0]  VinMaxHz  = 26'd2000000;
	localparam logic [VcoWidth-1:0] VcoMinHz  = 35'd100000000;
	localparam logic [VcoWidth-1:0] VcoMaxHz  = 35'd432000000;
	localparam logic [31:0]         RecipThree = 32'hAAAAAAAB;

	typedef struct packed {
		logic                bad;
		logic                pll_sel;
		logic                pll_range_ok;
		logic [DivBits-1:0]  direct_hz;
		logic [1:0]          p_code;
		logic [8:0]          n;
		logic [3:0]          ahb_sh;
		logic [2:0]          apb1_sh;
		logic [2:0]          apb2_sh;
		logic [3:0]          lat;
	} ctl_t;

	typedef struct packed {
		logic [MWidth-1:0]   rem;
		logic [DivBits-1:0]  dvd;
		logic [DivBits-1:0]  quo;
		logic [MWidth-1:0]   m;
	} div_t;

	function automatic logic [3:0] ahb_shift(input logic [3:0] code);
		logic [3:0] sh;
		case (code)
			4'd8:    sh = 4'd1;
			4'd9:    sh = 4'd2;
			4'd10:   sh = 4'd3;
			4'd11:   sh = 4'd4;
			4'd12:   sh = 4'd6;
			4'd13:   sh = 4'd7;
			4'd14:   sh = 4'd8;
			4'd15:   sh = 4'd9;
			default: sh = 4'd0;
		endcase
		return sh;
	endfunction

	function automatic logic [2:0] apb_shift(input logic [2:0] code);
		return code[2] ? {1'b0, code[1:0]} + 3'd1 : 3'd0;
	endfunction

	function automatic logic [2:0] auto_ws(input logic [SysWidth-1:0] hclk);
		logic [2:0] ws;
		if (hclk <= 28'd30000000) begin
			ws = 3'd0;
		end else if (hclk <= 28'd60000000) begin
			ws = 3'd1;
		end else if (hclk <= 28'd90000000) begin
			ws = 3'd2;
		end else if (hclk <= 28'd120000000) begin
			ws = 3'd3;
		end else if (hclk <= 28'd150000000) begin
			ws = 3'd4;
		end else begin
			ws = 3'd5;
		end
		return ws;
	endfunction

endpackage

// ===== rtl/clock_tree_config_checker.sv =====
// Clock-tree setting checker. Takes one proposed setting per cycle while the
// output is not stalled and returns one result per item. The pipeline is an
// input register, the PLL input divider (one quotient bit per stage), the VCO
// multiply, the divide-by-three reciprocal multiply and the final limit and
// prescaler stage. A stalled output holds the whole pipeline. The user must
// write oscillator frequencies through cfg_we/cfg_index/cfg_data only while
// the block is idle; not enforced here. Index 0 is external, 1 internal.
module clock_tree_config_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [25:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  sys_source,
	input  logic        pll_from_external,
	input  logic [6:0]  pll_m,
	input  logic [8:0]  pll_n,
	input  logic [2:0]  pll_p_code,
	input  logic [4:0]  pll_q,
	input  logic [3:0]  ahb_code,
	input  logic [2:0]  apb1_code,
	input  logic [2:0]  apb2_code,
	input  logic [3:0]  latency_request,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        status,
	output logic [27:0] sys_freq_hz,
	output logic [27:0] ahb_freq_hz,
	output logic [25:0] apb1_freq_hz,
	output logic [26:0] apb2_freq_hz,
	output logic [2:0]  wait_states
);
	import ctcc_pkg::*;

	logic [24:0] hse_q;
	logic [25:0] hsi_q;

	logic        en;
	ctl_t        ctl_in;
	div_t        dv_in;
	logic [25:0] ref_hz;

	logic        vld_sd [0:DivBits];
	ctl_t        ctl_sd [0:DivBits];
	div_t        dv_sd  [0:DivBits];

	logic                vld_s2;
	ctl_t                ctl_s2;
	logic                vin_ok_s2;
	logic [VcoWidth-1:0] vco_s2;

	logic        vld_s3;
	ctl_t        ctl_s3;
	logic        vco_ok_s3;
	logic [28:0] vco_s3;
	logic [59:0] prod_s3;

	logic [SysWidth-1:0] pll_hz;
	logic [SysWidth-1:0] sys_hz;
	logic [SysWidth-1:0] hclk;
	logic [SysWidth-1:0] pclk1;
	logic [SysWidth-1:0] pclk2;
	logic                bad;
	logic [2:0]          ws;

	logic        vld_s4;

	assign en       = !vld_s4 || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hse_q <= 25'd8000000;
			hsi_q <= 26'd16000000;
		end else if (cfg_we) begin
			if (cfg_index == RegHse) begin
				hse_q <= cfg_data[24:0];
			end else begin
				hsi_q <= cfg_data;
			end
		end
	end

	// decode
	always_comb begin
		ref_hz = pll_from_external ? {1'b0, hse_q} : hsi_q;
		ctl_in.bad = (sys_source == SrcBad)
			|| (ahb_code >= 4'd1 && ahb_code <= 4'd7)
			|| (apb1_code >= 3'd1 && apb1_code <= 3'd3)
			|| (apb2_code >= 3'd1 && apb2_code <= 3'd3)
			|| (latency_request > 4'd8);
		ctl_in.pll_sel = (sys_source == SrcPll);
		ctl_in.pll_range_ok = (pll_m >= 7'd2) && (pll_m <= 7'd63)
			&& (pll_n >= 9'd50) && (pll_n <= 9'd432)
			&& (pll_p_code <= 3'd3)
			&& (pll_q >= 5'd2) && (pll_q <= 5'd15);
		ctl_in.direct_hz = (sys_source == SrcHse) ? {1'b0, hse_q} : hsi_q;
		ctl_in.p_code    = pll_p_code[1:0];
		ctl_in.n         = pll_n;
		ctl_in.ahb_sh    = ahb_shift(ahb_code);
		ctl_in.apb1_sh   = apb_shift(apb1_code);
		ctl_in.apb2_sh   = apb_shift(apb2_code);
		ctl_in.lat       = latency_request;
		dv_in.rem = '0;
		dv_in.dvd = ref_hz;
		dv_in.quo = '0;
		dv_in.m   = pll_m;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sd[0] <= 1'b0;
		end else if (en) begin
			vld_sd[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_sd[0] <= ctl_in;
			dv_sd[0]  <= dv_in;
		end
	end

	// restoring divider, one quotient bit per stage
	for (genvar i = 0; i < DivBits; i++) begin : g_div
		logic [MWidth:0] trial;
		logic            ge;

		always_comb begin
			trial = {dv_sd[i].rem, dv_sd[i].dvd[DivBits-1]};
			ge    = trial >= {1'b0, dv_sd[i].m};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sd[i+1] <= 1'b0;
			end else if (en) begin
				vld_sd[i+1] <= vld_sd[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctl_sd[i+1]     <= ctl_sd[i];
				dv_sd[i+1].rem  <= ge ? MWidth'(trial - {1'b0, dv_sd[i].m})
					: trial[MWidth-1:0];
				dv_sd[i+1].dvd  <= {dv_sd[i].dvd[DivBits-2:0], 1'b0};
				dv_sd[i+1].quo  <= {dv_sd[i].quo[DivBits-2:0], ge};
				dv_sd[i+1].m    <= dv_sd[i].m;
			end
		end
	end

	// vco multiply, then divide-by-three reciprocal
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_sd[DivBits];
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s2    <= ctl_sd[DivBits];
			vin_ok_s2 <= (dv_sd[DivBits].quo >= VinMinHz)
				&& (dv_sd[DivBits].quo <= VinMaxHz);
			vco_s2    <= VcoWidth'(dv_sd[DivBits].quo) * VcoWidth'(ctl_sd[DivBits].n);
			ctl_s3    <= ctl_s2;
			vco_ok_s3 <= vin_ok_s2 && (vco_s2 >= VcoMinHz) && (vco_s2 <= VcoMaxHz);
			vco_s3    <= vco_s2[28:0];
			prod_s3   <= {32'd0, vco_s2[28:1]} * {28'd0, RecipThree};
		end
	end

	// pll output, bus clocks, limits
	always_comb begin
		case (ctl_s3.p_code)
			PDiv2:   pll_hz = vco_s3[28:1];
			PDiv4:   pll_hz = {1'b0, vco_s3[28:2]};
			PDiv6:   pll_hz = {1'b0, prod_s3[59:33]};
			PDiv8:   pll_hz = {2'b0, vco_s3[28:3]};
			default: pll_hz = '0;
		endcase
		sys_hz = ctl_s3.pll_sel ? pll_hz : {2'b0, ctl_s3.direct_hz};
		hclk   = sys_hz >> ctl_s3.ahb_sh;
		pclk1  = hclk >> ctl_s3.apb1_sh;
		pclk2  = hclk >> ctl_s3.apb2_sh;
		bad    = ctl_s3.bad
			|| (ctl_s3.pll_sel && !(ctl_s3.pll_range_ok && vco_ok_s3))
			|| (sys_hz > SysMaxHz) || (hclk > SysMaxHz)
			|| (pclk1 > Apb1MaxHz) || (pclk2 > Apb2MaxHz);
		ws     = (ctl_s3.lat == 4'd0) ? auto_ws(hclk) : 3'(ctl_s3.lat - 4'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			status       <= bad;
			sys_freq_hz  <= bad ? '0 : sys_hz;
			ahb_freq_hz  <= bad ? '0 : hclk;
			apb1_freq_hz <= bad ? '0 : pclk1[25:0];
			apb2_freq_hz <= bad ? '0 : pclk2[26:0];
			wait_states  <= bad ? '0 : ws;
		end
	end

	assign out_valid = vld_s4;

endmodule

// ===== rtl/ctcc_checker.sv =====
module ctcc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        status,
	input logic [27:0] sys_freq_hz,
	input logic [27:0] ahb_freq_hz,
	input logic [25:0] apb1_freq_hz,
	input logic [26:0] apb2_freq_hz,
	input logic [2:0]  wait_states
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)
			&& $stable(sys_freq_hz) && $stable(ahb_freq_hz) && $stable(wait_states))
		else $error("result changed under stall");

	// a stalled output blocks the input
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

	// invalid result carries zeros
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> sys_freq_hz == 28'd0 && ahb_freq_hz == 28'd0
			&& apb1_freq_hz == 26'd0 && apb2_freq_hz == 27'd0 && wait_states == 3'd0)
		else $error("invalid item with nonzero outputs");

	// valid result within bus limits
	a_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !status |-> ahb_freq_hz <= sys_freq_hz
			&& apb1_freq_hz <= 26'd42000000 && apb2_freq_hz <= 27'd84000000)
		else $error("valid item beyond bus limits");

endmodule

bind clock_tree_config_checker ctcc_checker u_ctcc_checker (.*);

// ===== sim/clock_tree_config_monitor.sv =====
`timescale 1ns / 100ps

module clock_tree_config_monitor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [25:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  sys_source,
	input  logic        pll_from_external,
	input  logic [6:0]  pll_m,
	input  logic [8:0]  pll_n,
	input  logic [2:0]  pll_p_code,
	input  logic [4:0]  pll_q,
	input  logic [3:0]  ahb_code,
	input  logic [2:0]  apb1_code,
	input  logic [2:0]  apb2_code,
	input  logic [3:0]  latency_request,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        status,
	input  logic [27:0] sys_freq_hz,
	input  logic [27:0] ahb_freq_hz,
	input  logic [25:0] apb1_freq_hz,
	input  logic [26:0] apb2_freq_hz,
	input  logic [2:0]  wait_states,
	output int          fail_count,
	output int          pending
);
	import ctcc_pkg::*;

	typedef struct packed {
		logic        bad;
		logic [27:0] sys;
		logic [27:0] ahb;
		logic [25:0] apb1;
		logic [26:0] apb2;
		logic [2:0]  ws;
	} clk_plan_t;

	clk_plan_t plans[$];
	logic [24:0] hse_hz;
	logic [25:0] hsi_hz;

	function automatic clk_plan_t plan_clocks(input logic [1:0] src, input logic pext,
		input logic [6:0] m, input logic [8:0] n, input logic [2:0] p, input logic [4:0] q,
		input logic [3:0] ahb, input logic [2:0] a1, input logic [2:0] a2,
		input logic [3:0] lat);
		clk_plan_t r;
		longint unsigned ref_hz, vin, vco, sys, h, p1, p2;
		int unsigned hdiv, d1, d2;
		r = '0;
		r.bad = 1'b1;
		if (src == SrcBad) return r;
		if ((ahb >= 1 && ahb <= 7) || (a1 >= 1 && a1 <= 3) || (a2 >= 1 && a2 <= 3) || lat > 8)
			return r;
		if (src == SrcHsi) begin
			sys = hsi_hz;
		end else if (src == SrcHse) begin
			sys = hse_hz;
		end else begin
			if (m < 2 || m > 63 || n < 50 || n > 432 || p > 3 || q < 2 || q > 15) return r;
			ref_hz = pext ? hse_hz : hsi_hz;
			vin = ref_hz / m;
			vco = vin * n;
			sys = vco / ((p + 1) * 2);
			if (vin < 1000000 || vin > 2000000 || vco < 100000000 || vco > 432000000
				|| sys > 168000000) return r;
		end
		hdiv = (ahb < 8) ? 1 : ((ahb < 12) ? (2 << (ahb - 8)) : (64 << (ahb - 12)));
		d1 = (a1 < 4) ? 1 : (2 << (a1 - 4));
		d2 = (a2 < 4) ? 1 : (2 << (a2 - 4));
		h = sys / hdiv;
		p1 = h / d1;
		p2 = h / d2;
		if (sys > 168000000 || h > 168000000 || p1 > 42000000 || p2 > 84000000) return r;
		r.bad = 1'b0;
		r.sys = 28'(sys);
		r.ahb = 28'(h);
		r.apb1 = 26'(p1);
		r.apb2 = 27'(p2);
		if (lat != 0) r.ws = 3'(lat - 4'd1);
		else if (h <= 30000000) r.ws = 3'd0;
		else if (h <= 60000000) r.ws = 3'd1;
		else if (h <= 90000000) r.ws = 3'd2;
		else if (h <= 120000000) r.ws = 3'd3;
		else if (h <= 150000000) r.ws = 3'd4;
		else r.ws = 3'd5;
		return r;
	endfunction

	assign pending = plans.size();

	always @(posedge clk or negedge arst_n) begin
		clk_plan_t e;
		if (!arst_n) begin
			hse_hz <= 25'd8000000;
			hsi_hz <= 26'd16000000;
			fail_count <= 0;
			plans.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == RegHse) hse_hz <= cfg_data[24:0];
				else hsi_hz <= cfg_data;
			end
			if (in_valid && in_ready)
				plans.push_back(plan_clocks(sys_source, pll_from_external, pll_m, pll_n,
					pll_p_code, pll_q, ahb_code, apb1_code, apb2_code, latency_request));
			if (out_valid && out_ready) begin
				if (plans.size() == 0) begin
					$error("unexpected item");
					fail_count <= fail_count + 1;
				end else begin
					e = plans.pop_front();
					if (status !== e.bad || sys_freq_hz !== e.sys || ahb_freq_hz !== e.ahb
						|| apb1_freq_hz !== e.apb1 || apb2_freq_hz !== e.apb2
						|| wait_states !== e.ws)
						fail_count <= fail_count + 1;
					if (status !== e.bad)
						$error("status exp %0d got %0d", e.bad, status);
					if (sys_freq_hz !== e.sys)
						$error("sys_freq_hz exp %0d got %0d", e.sys, sys_freq_hz);
					if (ahb_freq_hz !== e.ahb)
						$error("ahb_freq_hz exp %0d got %0d", e.ahb, ahb_freq_hz);
					if (apb1_freq_hz !== e.apb1)
						$error("apb1_freq_hz exp %0d got %0d", e.apb1, apb1_freq_hz);
					if (apb2_freq_hz !== e.apb2)
						$error("apb2_freq_hz exp %0d got %0d", e.apb2, apb2_freq_hz);
					if (wait_states !== e.ws)
						$error("wait_states exp %0d got %0d", e.ws, wait_states);
				end
			end
		end
	end
endmodule

// ===== sim/clock_tree_config_checker_tb.sv =====
`timescale 1ns / 100ps

module clock_tree_config_checker_tb;
	import ctcc_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [25:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] sys_source = '0;
	logic pll_from_external = 1'b0;
	logic [6:0] pll_m = '0;
	logic [8:0] pll_n = '0;
	logic [2:0] pll_p_code = '0;
	logic [4:0] pll_q = '0;
	logic [3:0] ahb_code = '0;
	logic [2:0] apb1_code = '0;
	logic [2:0] apb2_code = '0;
	logic [3:0] latency_request = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic status;
	logic [27:0] sys_freq_hz, ahb_freq_hz;
	logic [25:0] apb1_freq_hz;
	logic [26:0] apb2_freq_hz;
	logic [2:0] wait_states;
	int fail_count, pending;
	int cycles = 0;
	bit no_stall = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	clock_tree_config_checker dut (.*);
	clock_tree_config_monitor mon (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 600000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(negedge clk) begin
		int gap;
		if (arst_n) begin
			if (no_stall) begin
				out_ready <= 1'b1;
			end else if (out_valid && out_ready) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
				out_ready <= (gap == 0);
				repeat (gap) @(negedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_setting(input logic [1:0] src, input logic pext, input logic [6:0] m,
		input logic [8:0] n, input logic [2:0] p, input logic [4:0] q, input logic [3:0] ahb,
		input logic [2:0] a1, input logic [2:0] a2, input logic [3:0] lat);
		int gap;
		gap = no_stall ? 0 : $urandom_range(0, 14);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sys_source <= src;
		pll_from_external <= pext;
		pll_m <= m;
		pll_n <= n;
		pll_p_code <= p;
		pll_q <= q;
		ahb_code <= ahb;
		apb1_code <= a1;
		apb2_code <= a2;
		latency_request <= lat;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic send_random(input bit legal);
		logic [3:0] ahb;
		if (legal) begin
			ahb = $urandom_range(0, 8) == 0 ? 4'd0 : 4'($urandom_range(8, 15));
			if ($urandom_range(0, 3) == 0) ahb = 4'd0;
			send_setting($urandom_range(0, 3) == 0 ? 2'($urandom_range(0, 1)) : SrcPll,
				1'($urandom), 7'($urandom_range(2, 20)), 9'($urandom_range(50, 432)),
				3'($urandom_range(0, 3)), 5'($urandom_range(2, 15)), ahb,
				$urandom_range(0, 1) ? 3'd0 : 3'($urandom_range(4, 7)),
				$urandom_range(0, 1) ? 3'd0 : 3'($urandom_range(4, 7)),
				$urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(1, 8)));
		end else begin
			send_setting(2'($urandom), 1'($urandom), 7'($urandom), 9'($urandom),
				3'($urandom), 5'($urandom), 4'($urandom), 3'($urandom), 3'($urandom),
				4'($urandom));
		end
	endtask

	task automatic drain;
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (pending != 0 && guard < 20000) begin
			@(negedge clk);
			guard++;
		end
		repeat (40) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [25:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int k;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_setting(SrcHsi, 0, 0, 0, 0, 0, 4'd0, 3'd4, 3'd0, 4'd0);
		send_setting(SrcHse, 1, 127, 511, 7, 31, 4'd15, 3'd7, 3'd7, 4'd8);
		send_setting(SrcBad, 0, 8, 336, 1, 7, 4'd0, 3'd5, 3'd4, 4'd0);
		send_setting(SrcPll, 1, 8, 336, 0, 7, 4'd0, 3'd5, 3'd4, 4'd0);
		send_setting(SrcPll, 0, 16, 336, 1, 7, 4'd0, 3'd5, 3'd4, 4'd6);
		send_setting(SrcPll, 1, 8, 336, 1, 7, 4'd3, 3'd5, 3'd4, 4'd0);
		send_setting(SrcPll, 1, 8, 336, 1, 7, 4'd0, 3'd2, 3'd4, 4'd0);
		send_setting(SrcPll, 1, 8, 336, 1, 7, 4'd0, 3'd5, 3'd1, 4'd0);
		send_setting(SrcPll, 1, 8, 336, 1, 7, 4'd0, 3'd5, 3'd4, 4'd9);
		send_setting(SrcPll, 1, 1, 336, 1, 7, 4'd0, 3'd5, 3'd4, 4'd0);
		send_setting(SrcPll, 1, 64, 336, 1, 7, 4'd0, 3'd5, 3'd4, 4'd0);
		send_setting(SrcPll, 1, 8, 49, 1, 7, 4'd0, 3'd5, 3'd4, 4'd0);
		send_setting(SrcPll, 1, 8, 433, 1, 7, 4'd0, 3'd5, 3'd4, 4'd0);
		send_setting(SrcPll, 1, 8, 336, 4, 7, 4'd0, 3'd5, 3'd4, 4'd0);
		send_setting(SrcPll, 1, 8, 336, 1, 1, 4'd0, 3'd5, 3'd4, 4'd0);
		send_setting(SrcPll, 1, 8, 336, 1, 16, 4'd0, 3'd5, 3'd4, 4'd0);
		send_setting(SrcPll, 1, 2, 100, 1, 2, 4'd0, 3'd5, 3'd4, 4'd0);
		send_setting(SrcPll, 1, 8, 60, 3, 15, 4'd8, 3'd0, 3'd0, 4'd1);
		send_setting(SrcPll, 1, 8, 432, 0, 7, 4'd8, 3'd6, 3'd5, 4'd0);
		send_setting(SrcHsi, 0, 0, 0, 0, 0, 4'd12, 3'd0, 3'd0, 4'd0);
		drain();
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin write_reg(RegHse, 26'd4000000); write_reg(RegHsi, 26'd1000000); end
				1: begin write_reg(RegHse, 26'd26000000); write_reg(RegHsi, 26'd64000000); end
				2: begin write_reg(RegHse, 26'h3FFFFFF); write_reg(RegHsi, 26'h3FFFFFF); end
				3: begin write_reg(RegHse, 26'd0); write_reg(RegHsi, 26'd0); end
				4: begin write_reg(RegHse, 26'd25000000); write_reg(RegHsi, 26'd16000000); end
				default: begin
					write_reg(RegHse, 26'($urandom_range(4000000, 26000000)));
					write_reg(RegHsi, 26'($urandom_range(1000000, 64000000)));
				end
			endcase
			no_stall = (phase == 4);
			for (k = 0; k < 270; k++) begin
				send_random($urandom_range(0, 4) != 0);
				if (phase == 1 && k == 100) drain();
			end
			drain();
		end
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

// ===== clock_tree_config_checker.f =====
rtl/ctcc_pkg.sv
rtl/clock_tree_config_checker.sv
rtl/ctcc_checker.sv
sim/clock_tree_config_monitor.sv
sim/clock_tree_config_checker_tb.sv
